>>> design/rslp_pkg.sv
// ----------------------------------------------------------------------------
// rslp_pkg
// shared constants, byte classes and queue types of the range sensor line
// parser
// ----------------------------------------------------------------------------
package rslp_pkg;

  localparam int LINE_BYTES_DEF   = 64;
  localparam int TOKEN_BYTES_DEF  = 8;
  localparam int SENSOR_COUNT_DEF = 4;

  localparam int OUT_RANGES  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] THRESH_RESET = 16'd250;
  localparam logic [19:0] RANGE_MAX    = 20'd65535;

  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_COMMA = 8'h2c;
  localparam logic [7:0] CHR_U     = 8'h55;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CLS_LF,
    CLS_NUL,
    CLS_COMMA,
    CLS_DIGIT,
    CLS_U,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
  } q_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

>>> design/range_sensor_line_parser.sv
// ----------------------------------------------------------------------------
// range_sensor_line_parser
// parses the range sensor text stream a byte at a time into range frames
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_rx_byte
//   out_     output     out_valid/out_stall  frame_ok, range_a..d, obstacle_stop
//   cfg_     input      cfg_we               cfg_wdata (stop threshold)
//
// one byte per cycle sustained unless out_stall holds a waiting result
// the line feed passes the front register and the queue before out_valid rises
// synchronous active-low reset; threshold resets to 250, latched ranges to zero
// in_stall rises only when the four-entry queue and the front register are full
// out_stall holds the result register; while a result waits it stops the queue
// draining
// ----------------------------------------------------------------------------
module range_sensor_line_parser #(
  parameter int LINE_BYTES   = rslp_pkg::LINE_BYTES_DEF,
  parameter int TOKEN_BYTES  = rslp_pkg::TOKEN_BYTES_DEF,
  parameter int SENSOR_COUNT = rslp_pkg::SENSOR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_ok,
  output logic [15:0] out_range_a,
  output logic [15:0] out_range_b,
  output logic [15:0] out_range_c,
  output logic [15:0] out_range_d,
  output logic        out_obstacle_stop
);
  import rslp_pkg::*;

  q_stat_t  q_stat;
  q_entry_t q_wdata;
  q_entry_t q_rdata;
  logic     q_push;
  logic     q_pop;

  rslp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  rslp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  rslp_back #(
    .LINE_BYTES   (LINE_BYTES),
    .TOKEN_BYTES  (TOKEN_BYTES),
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .q_stat            (q_stat),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_ok      (out_frame_ok),
    .out_range_a       (out_range_a),
    .out_range_b       (out_range_b),
    .out_range_c       (out_range_c),
    .out_range_d       (out_range_d),
    .out_obstacle_stop (out_obstacle_stop)
  );

endmodule

>>> design/rslp_front.sv
// ----------------------------------------------------------------------------
// rslp_front
// accepts input beats, drops carriage returns and classifies each byte
// ----------------------------------------------------------------------------
module rslp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  rslp_pkg::q_stat_t q_stat,
  output logic              q_push,
  output rslp_pkg::q_entry_t q_wdata
);
  import rslp_pkg::*;

  logic     fe_vld_r, fe_vld_nxt;
  q_entry_t fe_ent_r, fe_ent_nxt;
  logic     accept;
  logic     is_cr;

  assign in_stall = fe_vld_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = fe_vld_r && !q_stat.full;
  assign q_wdata  = fe_ent_r;
  assign is_cr    = (in_rx_byte == CHR_CR);

  always_comb begin
    fe_ent_nxt.digit = 4'(in_rx_byte - CHR_ZERO);
    if (in_rx_byte == CHR_LF) begin
      fe_ent_nxt.cls = CLS_LF;
    end else if (in_rx_byte == CHR_NUL) begin
      fe_ent_nxt.cls = CLS_NUL;
    end else if (in_rx_byte == CHR_COMMA) begin
      fe_ent_nxt.cls = CLS_COMMA;
    end else if (in_rx_byte >= CHR_ZERO && in_rx_byte <= CHR_NINE) begin
      fe_ent_nxt.cls = CLS_DIGIT;
    end else if (in_rx_byte == CHR_U) begin
      fe_ent_nxt.cls = CLS_U;
    end else begin
      fe_ent_nxt.cls = CLS_OTHER;
    end
  end

  always_comb begin
    fe_vld_nxt = fe_vld_r;
    if (accept) begin
      fe_vld_nxt = !is_cr;
    end else if (q_push) begin
      fe_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_vld_r <= 1'b0;
    end else begin
      fe_vld_r <= fe_vld_nxt;
    end
    if (accept) begin
      fe_ent_r <= fe_ent_nxt;
    end
  end

endmodule

>>> design/rslp_queue.sv
// ----------------------------------------------------------------------------
// rslp_queue
// short queue of classified bytes between the front and the back
// ----------------------------------------------------------------------------
module rslp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rslp_pkg::q_entry_t wdata,
  input  logic               pop,
  output rslp_pkg::q_entry_t rdata,
  output rslp_pkg::q_stat_t  stat
);
  import rslp_pkg::*;

  q_entry_t        mem_r [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QA_W:0]   cnt_r, cnt_nxt;

  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == (QA_W+1)'(QUEUE_DEPTH));
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> design/rslp_back.sv
// ----------------------------------------------------------------------------
// rslp_back
// incremental line parse, latched ranges, threshold and result register
// ----------------------------------------------------------------------------
module rslp_back #(
  parameter int LINE_BYTES   = rslp_pkg::LINE_BYTES_DEF,
  parameter int TOKEN_BYTES  = rslp_pkg::TOKEN_BYTES_DEF,
  parameter int SENSOR_COUNT = rslp_pkg::SENSOR_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  rslp_pkg::q_stat_t  q_stat,
  input  rslp_pkg::q_entry_t q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_ok,
  output logic [15:0]        out_range_a,
  output logic [15:0]        out_range_b,
  output logic [15:0]        out_range_c,
  output logic [15:0]        out_range_d,
  output logic               out_obstacle_stop
);
  import rslp_pkg::*;

  localparam int LL_W = $clog2(LINE_BYTES);
  localparam int TC_W = $clog2(TOKEN_BYTES);
  localparam int FI_W = $clog2(SENSOR_COUNT + 1);

  logic [15:0]     thr_r;
  logic [LL_W-1:0] len_r, len_nxt;
  logic [FI_W-1:0] fi_r, fi_nxt;
  logic [TC_W-1:0] tc_r, tc_nxt;
  logic [15:0]     acc_r, acc_nxt;
  logic            err_r, err_nxt;
  logic            end_r, end_nxt;
  logic [15:0]     pend_r [SENSOR_COUNT];
  logic [15:0]     pend_nxt [SENSOR_COUNT];
  logic [15:0]     lat_r [SENSOR_COUNT];
  logic [15:0]     lat_nxt [SENSOR_COUNT];

  logic            ov_r, ov_nxt;
  logic            ok_r, ok_nxt;
  logic            stop_r, stop_nxt;
  logic [15:0]     rng_r [OUT_RANGES];
  logic [15:0]     rng_src [OUT_RANGES];

  logic            emit, take, latch, clr;
  logic            fin_bad, fin_short, fi_full;
  logic [19:0]     dig_v;

  assign q_pop     = q_stat.valid && (!ov_r || !out_stall);
  assign fi_full   = (fi_r >= FI_W'(SENSOR_COUNT));
  assign fin_bad   = (len_r < LL_W'(2)) || (tc_r == '0) || fi_full;
  assign fin_short = (fi_r < FI_W'(SENSOR_COUNT - 1));
  assign dig_v     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                   + {16'h0000, q_rdata.digit};

  always_comb begin
    len_nxt  = len_r;
    fi_nxt   = fi_r;
    tc_nxt   = tc_r;
    acc_nxt  = acc_r;
    err_nxt  = err_r;
    end_nxt  = end_r;
    pend_nxt = pend_r;
    lat_nxt  = lat_r;
    emit     = 1'b0;
    take     = 1'b0;
    latch    = 1'b0;
    clr      = 1'b0;
    stop_nxt = 1'b0;

    if (q_pop) begin
      case (q_rdata.cls)
        CLS_LF: begin
          if (len_r != '0) begin
            emit  = 1'b1;
            latch = 1'b1;
            clr   = 1'b1;
            if (!end_r && !err_r) begin
              if (fin_bad) begin
                err_nxt = 1'b1;
              end else begin
                take = 1'b1;
                if (fin_short) err_nxt = 1'b1;
              end
            end
          end
        end
        default: begin
          if (len_r == LL_W'(LINE_BYTES - 1)) begin
            clr = 1'b1;
          end else begin
            len_nxt = len_r + 1'b1;
            if (!end_r && !err_r) begin
              if (q_rdata.cls == CLS_NUL) begin
                end_nxt = 1'b1;
                if (fin_bad) begin
                  err_nxt = 1'b1;
                end else begin
                  take = 1'b1;
                  if (fin_short) err_nxt = 1'b1;
                end
              end else if (len_r == '0) begin
                if (q_rdata.cls != CLS_U) err_nxt = 1'b1;
              end else if (len_r == LL_W'(1)) begin
                if (q_rdata.cls != CLS_COMMA) err_nxt = 1'b1;
              end else if (fi_full) begin
                err_nxt = 1'b1;
              end else if (q_rdata.cls == CLS_COMMA) begin
                if (tc_r == '0) begin
                  err_nxt = 1'b1;
                end else begin
                  take = 1'b1;
                  if (!fin_short) err_nxt = 1'b1;
                end
              end else if (tc_r >= TC_W'(TOKEN_BYTES - 1)) begin
                take    = 1'b1;
                err_nxt = 1'b1;
              end else if (q_rdata.cls != CLS_DIGIT) begin
                err_nxt = 1'b1;
              end else if (dig_v > RANGE_MAX) begin
                err_nxt = 1'b1;
              end else begin
                acc_nxt = dig_v[15:0];
                tc_nxt  = tc_r + 1'b1;
              end
            end
          end
        end
      endcase
    end

    if (take) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (fi_r == FI_W'(i)) pend_nxt[i] = acc_r;
      end
      fi_nxt  = fi_r + 1'b1;
      tc_nxt  = '0;
      acc_nxt = '0;
    end

    if (latch) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (FI_W'(i) < fi_nxt) lat_nxt[i] = pend_nxt[i];
      end
    end

    ok_nxt = !err_nxt;

    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (lat_nxt[i] != '0 && lat_nxt[i] < thr_r) stop_nxt = 1'b1;
    end

    if (clr) begin
      len_nxt = '0;
      fi_nxt  = '0;
      tc_nxt  = '0;
      acc_nxt = '0;
      err_nxt = 1'b0;
      end_nxt = 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        pend_nxt[i] = '0;
      end
    end

    ov_nxt = ov_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  for (genvar g = 0; g < OUT_RANGES; g++) begin : g_rng
    if (g < SENSOR_COUNT) begin : g_used
      assign rng_src[g] = lat_nxt[g];
    end else begin : g_unused
      assign rng_src[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
      len_r <= '0;
      fi_r  <= '0;
      tc_r  <= '0;
      acc_r <= '0;
      err_r <= 1'b0;
      end_r <= 1'b0;
      ov_r  <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        pend_r[i] <= '0;
        lat_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      len_r  <= len_nxt;
      fi_r   <= fi_nxt;
      tc_r   <= tc_nxt;
      acc_r  <= acc_nxt;
      err_r  <= err_nxt;
      end_r  <= end_nxt;
      ov_r   <= ov_nxt;
      pend_r <= pend_nxt;
      lat_r  <= lat_nxt;
    end
    if (emit) begin
      ok_r   <= ok_nxt;
      stop_r <= stop_nxt;
      rng_r  <= rng_src;
    end
  end

  assign out_valid         = ov_r;
  assign out_frame_ok      = ok_r;
  assign out_range_a       = rng_r[0];
  assign out_range_b       = rng_r[1];
  assign out_range_c       = rng_r[2];
  assign out_range_d       = rng_r[3];
  assign out_obstacle_stop = stop_r;

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks range_sensor_line_parser: sensor text lines go in one byte per beat,
// and a line parser of its own predicts each frame beat that a line feed
// should produce. A short table of hand-made lines runs first. Random lines
// follow, mostly well formed with random numbers, plus damaged lines, lines
// cut short by a NUL, overlong lines and noise. The stop threshold changes
// between phases, and each phase sets how often the two channels idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rslp_pkg::*;

  typedef struct packed {
    logic        frame_ok;
    logic [15:0] range_a;
    logic [15:0] range_b;
    logic [15:0] range_c;
    logic [15:0] range_d;
    logic        obstacle_stop;
  } frame_t;

  typedef struct {
    string  txt;
    bit     typed;
    frame_t want;
  } row_t;

  // stands for a NUL byte in the text of the table
  localparam logic [7:0] NUL_MARK = "@";
  localparam int PHASES = 5;
  localparam int PHASE_BYTES = 310;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_frame_ok;
  logic [15:0] out_range_a;
  logic [15:0] out_range_b;
  logic [15:0] out_range_c;
  logic [15:0] out_range_d;
  logic        out_obstacle_stop;

  int unsigned snd_idle = 0;
  int unsigned rcv_stall = 0;
  int unsigned bytes_sent = 0;
  int unsigned fails = 0;
  bit          use_typed = 1'b0;
  frame_t      typed_frame = '0;
  frame_t      frames_due[$];
  row_t        plan[$];

  // line parser state
  logic [15:0] stop_mm = THRESH_RESET;
  int unsigned held_len = 0;
  int unsigned num_idx = 0;
  int unsigned num_digits = 0;
  logic [16:0] num_val = '0;
  bit          bad_line = 1'b0;
  bit          text_done = 1'b0;
  logic [15:0] ranges [OUT_RANGES] = '{default: '0};
  logic [15:0] staged [OUT_RANGES] = '{default: '0};

  range_sensor_line_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_ok     (out_frame_ok),
    .out_range_a      (out_range_a),
    .out_range_b      (out_range_b),
    .out_range_c      (out_range_c),
    .out_range_d      (out_range_d),
    .out_obstacle_stop(out_obstacle_stop)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void line_clear();
    held_len = 0;
    num_idx = 0;
    num_digits = 0;
    num_val = '0;
    bad_line = 1'b0;
    text_done = 1'b0;
    staged = '{default: '0};
  endfunction

  function automatic void commit_number();
    if (num_idx < SENSOR_COUNT_DEF) staged[num_idx] = num_val[15:0];
    num_idx++;
    num_digits = 0;
    num_val = '0;
  endfunction

  function automatic void end_text(int unsigned len);
    if (bad_line) return;
    if (len < 2 || num_digits == 0 || num_idx >= SENSOR_COUNT_DEF) begin
      bad_line = 1'b1;
      return;
    end
    commit_number();
    if (num_idx < SENSOR_COUNT_DEF) bad_line = 1'b1;
  endfunction

  function automatic bit parse_rx_byte(input logic [7:0] c, output frame_t f);
    int unsigned pos;
    int unsigned v;
    int i;
    f = '0;
    if (c == CHR_CR) return 1'b0;
    if (c != CHR_LF) begin
      if (held_len + 1 >= LINE_BYTES_DEF) begin
        line_clear();
        return 1'b0;
      end
      pos = held_len;
      held_len++;
      if (text_done || bad_line) return 1'b0;
      if (c == CHR_NUL) begin
        end_text(pos);
        text_done = 1'b1;
      end else if (pos == 0) begin
        if (c != CHR_U) bad_line = 1'b1;
      end else if (pos == 1) begin
        if (c != CHR_COMMA) bad_line = 1'b1;
      end else if (num_idx >= SENSOR_COUNT_DEF) begin
        bad_line = 1'b1;
      end else if (c == CHR_COMMA) begin
        if (num_digits == 0) begin
          bad_line = 1'b1;
        end else begin
          commit_number();
          if (num_idx >= SENSOR_COUNT_DEF) bad_line = 1'b1;
        end
      end else if (num_digits >= TOKEN_BYTES_DEF - 1) begin
        commit_number();
        bad_line = 1'b1;
      end else if (c < CHR_ZERO || c > CHR_NINE) begin
        bad_line = 1'b1;
      end else begin
        v = num_val * 10 + (c - CHR_ZERO);
        if (v > RANGE_MAX) begin
          bad_line = 1'b1;
        end else begin
          num_val = 17'(v);
          num_digits++;
        end
      end
      return 1'b0;
    end
    if (held_len == 0) return 1'b0;
    if (!text_done) end_text(held_len);
    f.frame_ok = !bad_line;
    for (i = 0; i < SENSOR_COUNT_DEF && i < int'(num_idx); i++) ranges[i] = staged[i];
    line_clear();
    for (i = 0; i < SENSOR_COUNT_DEF; i++) begin
      if (ranges[i] != 0 && ranges[i] < stop_mm) f.obstacle_stop = 1'b1;
    end
    f.range_a = ranges[0];
    f.range_b = ranges[1];
    f.range_c = ranges[2];
    f.range_d = ranges[3];
    return 1'b1;
  endfunction

  function automatic row_t row(string t, bit typed = 1'b0, frame_t want = '0);
    row_t r;
    r.txt = t;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // mode 0 plain, 1 more digits than a number may hold, 2 value above range
  function automatic string number_text(int unsigned mode);
    int unsigned v;
    int unsigned width;
    string s;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 600);
      3, 4, 5: v = $urandom_range(0, 65535);
      6, 7: begin
        v = (stop_mm > 3) ? stop_mm - 3 + $urandom_range(0, 6) : $urandom_range(0, 6);
        if (v > 65535) v = 65535;
      end
      default: v = $urandom_range(65530, 65535);
    endcase
    if (mode == 2) v = $urandom_range(65536, 99999);
    s = $sformatf("%0d", v);
    if (mode == 1) begin
      width = $urandom_range(8, 10);
      while (s.len() < width) s = {"0", s};
    end else if ($urandom_range(0, 3) == 0) begin
      width = $urandom_range(s.len(), TOKEN_BYTES_DEF - 1);
      while (s.len() < width) s = {"0", s};
    end
    return s;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    frame_t f;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (parse_rx_byte(b, f)) frames_due.push_back(use_typed ? typed_frame : f);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    stop_mm = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_line();
    logic [7:0] txt[$];
    logic [7:0] b;
    int unsigned kind, nums, sub, odd_num, k, at;
    string s;
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      repeat ($urandom_range(1, 20)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      // overlong filler, sometimes exactly one full line so the restart is clean
      if (kind >= 90) begin
        k = $urandom_range(0, 1) ? LINE_BYTES_DEF : $urandom_range(40, 80);
        repeat (k) begin
          b = 8'($urandom_range(0, 255));
          if (b == CHR_LF) b = CHR_U;
          txt.push_back(b);
        end
      end
      nums = SENSOR_COUNT_DEF;
      sub = $urandom_range(0, 3);
      if (kind >= 75 && kind < 80 && sub == 0) nums = SENSOR_COUNT_DEF - 1;
      if (kind >= 75 && kind < 80 && sub == 1) nums = SENSOR_COUNT_DEF + 1;
      odd_num = $urandom_range(0, nums - 1);
      txt.push_back(CHR_U);
      txt.push_back(CHR_COMMA);
      for (k = 0; k < nums; k++) begin
        if (k != 0) txt.push_back(CHR_COMMA);
        if (kind >= 75 && kind < 80 && sub == 3 && k == odd_num) continue;
        if (kind >= 85 && kind < 90 && k == odd_num) s = number_text(sub[0] ? 1 : 2);
        else s = number_text(0);
        for (at = 0; at < s.len(); at++) txt.push_back(s[at]);
      end
      if (kind >= 75 && kind < 80 && sub == 2) txt.push_back(CHR_COMMA);
      at = $urandom_range(0, txt.size() - 1);
      if (kind >= 60 && kind < 70) begin
        txt[at] = 8'($urandom_range(0, 255));
      end else if (kind >= 70 && kind < 75) begin
        txt.insert(at, 8'($urandom_range(0, 255)));
      end else if (kind >= 80 && kind < 85) begin
        txt.insert($urandom_range(0, txt.size()), CHR_NUL);
        repeat ($urandom_range(0, 6)) txt.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 60 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) txt.insert($urandom_range(0, txt.size()), CHR_CR);
      end
    end
    if ($urandom_range(0, 4) == 0) txt.push_back(CHR_CR);
    txt.push_back(CHR_LF);
    foreach (txt[i]) send_byte(txt[i]);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_stall);
  end

  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $error("result beat with no frame expected");
        fails++;
      end else begin
        want = frames_due.pop_front();
        check_field("frame_ok", want.frame_ok, out_frame_ok);
        check_field("range_a", want.range_a, out_range_a);
        check_field("range_b", want.range_b, out_range_b);
        check_field("range_c", want.range_c, out_range_c);
        check_field("range_d", want.range_d, out_range_d);
        check_field("obstacle_stop", want.obstacle_stop, out_obstacle_stop);
      end
    end
  end

  initial begin
    int unsigned ph, k, phase_end;
    int unsigned idle_pct [PHASES];
    int unsigned stall_pct [PHASES];
    logic [15:0] limit_mm [PHASES];
    string pad;
    logic [7:0] b;
    idle_pct = '{0, 60, 0, 21, 0};
    stall_pct = '{0, 0, 60, 21, 0};
    limit_mm = '{THRESH_RESET, 16'd0, 16'd65535, 16'($urandom_range(0, 65535)), 16'd1};
    pad = "";
    repeat (49) pad = {pad, "x"};
    plan.push_back(row("U,0,65535,1,249\n", 1'b1,
                       '{1'b1, 16'd0, 16'd65535, 16'd1, 16'd249, 1'b1}));
    plan.push_back(row("U,300,300,300,300\r\n", 1'b1,
                       '{1'b1, 16'd300, 16'd300, 16'd300, 16'd300, 1'b0}));
    plan.push_back(row("\r\n"));
    plan.push_back(row("U,0,0,0,0\n", 1'b1, '{1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}));
    plan.push_back(row("U,65536,1,2,3\n"));
    plan.push_back(row("U,00000012,5,5,5\n"));
    plan.push_back(row("U,1,2,3,4,\n"));
    plan.push_back(row("U,1,2,3\n"));
    plan.push_back(row("U,,2,3,4\n"));
    plan.push_back(row("U,1a,2,3,4\n"));
    plan.push_back(row("V,1,2,3,4\n"));
    plan.push_back(row("U;1,2,3,4\n"));
    plan.push_back(row("U,10,20,30,40@junk,\n"));
    plan.push_back(row("U,7@\n"));
    plan.push_back(row("U\n"));
    plan.push_back(row("U,\n"));
    plan.push_back(row("U,10,20,30,40,5\n"));
    plan.push_back(row("@\n"));
    plan.push_back(row({pad, "xxxxxxxxxxxxxx", "ZU,9,8,7,6\n"}));
    plan.push_back(row({"U,11,22,33,44@", pad, "\n"}));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        settle();
        write_threshold(limit_mm[ph]);
      end
      snd_idle = idle_pct[ph];
      rcv_stall = stall_pct[ph];
      if (ph == 0) begin
        foreach (plan[r]) begin
          use_typed = plan[r].typed;
          typed_frame = plan[r].want;
          for (k = 0; k < plan[r].txt.len(); k++) begin
            b = plan[r].txt[k];
            send_byte(b == NUL_MARK ? CHR_NUL : b);
          end
        end
        use_typed = 1'b0;
      end
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        send_random_line();
        // hold the sender until every frame has come out
        if ($urandom_range(0, 15) == 0) settle();
      end
    end
    settle();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
design/rslp_pkg.sv
design/rslp_front.sv
design/rslp_queue.sv
design/rslp_back.sv
design/range_sensor_line_parser.sv
test/tb_top.sv
